// ===== src/gcap_pkg.sv =====
// Shared types and constants for the gray / conv3x3 / ReLU / avgpool unit.
// No dependencies.
`default_nettype none
package gcap_pkg;
    localparam int GRAY_W  = 8;
    localparam int VALUE_W = 20;
    localparam int ROW_W   = 12;
    localparam int COL_W   = 10;
    localparam int MAX_H   = 4096;

    typedef enum logic [2:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_K_TOP  = 3'd2,
        REG_K_MID  = 3'd3,
        REG_K_BOT  = 3'd4,
        REG_SELECT = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        SEL_CONV = 2'd0,
        SEL_ACT  = 2'd1,
        SEL_POOL = 2'd2,
        SEL_ALT  = 2'd3
    } out_sel_t;

    // gray = floor((30r+50g+11b)/100); numerator < 23206.
    // floor(n/100) = (n*5243)>>19 holds for n < 43699.
    function automatic logic [GRAY_W-1:0] gray_of(input logic [7:0] r, input logic [7:0] g,
                                                  input logic [7:0] b);
        logic [14:0] n;
        logic [27:0] p;
        begin
            n = 15'(r) * 15'd30 + 15'(g) * 15'd50 + 15'(b) * 15'd11;
            p = 28'(n) * 28'd5243;
            gray_of = GRAY_W'(p >> 19);
        end
    endfunction
endpackage
`default_nettype wire

// ===== src/gray_conv3x3_activation_avgpool_unit.sv =====
// Gray / 3x3 conv / ReLU / 2x2 average pool over a raster RGB pixel stream.
// Uses gcap_pkg, gcap_line_mem, gcap_pool_mem.
// One pixel word is taken per cycle unless the output side stalls the
// pipeline. Pipeline: stage 1 computes gray, keeps the pixel position and reads
// the line memory at that column (registered read); stage 2 forms the nine-tap
// convolution from the window registers and the line data and writes the column
// back (rows shifted up); stage 3 applies ReLU and the pool pair, reading the
// pool memory at that pool column; stage 4 adds the row sum and forms the
// result, into an output register. Line reads hit a column written at least a
// full row (>=3 pixels) earlier, and pool entries are written one conv row
// before they are read, with at least the two leading pixel columns of a row in
// between, so neither memory needs forwarding. Stall on the output side freezes
// the whole pipeline, so in stall follows out stall only when a result waits. No
// clearing pass: unwritten entries are outside the contract. The user must write
// configuration only while idle; the block itself does not enforce it.
`default_nettype none
module gray_conv3x3_activation_avgpool_unit #(
    parameter int MAX_WIDTH = 1024,
    parameter int COEF_BITS = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [2:0]                       cfg_index,
    input  wire logic [((3*COEF_BITS > 13) ? 3*COEF_BITS : 13)-1:0] cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [7:0]                       red,
    input  wire logic [7:0]                       green,
    input  wire logic [7:0]                       blue,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic signed [gcap_pkg::VALUE_W-1:0]   value,
    output logic      [gcap_pkg::ROW_W-1:0]       out_row,
    output logic      [gcap_pkg::COL_W-1:0]       out_col,
    output logic                                  frame_last
);
    import gcap_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int PD  = MAX_WIDTH / 2;
    localparam int PAW = (AW > 1) ? AW - 1 : 1;
    localparam int KW  = 3 * COEF_BITS;

    // configuration
    logic [10:0]    width_reg;
    logic [12:0]    height_reg;
    logic [KW-1:0]  krow_reg [3];
    logic [1:0]     sel_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= 11'd1024;
            height_reg  <= 13'd1024;
            krow_reg[0] <= KW'(1);
            krow_reg[1] <= '0;
            krow_reg[2] <= KW'(1) << (2 * COEF_BITS + COEF_BITS - 1) |
                           ((KW'(1) << (2 * COEF_BITS + COEF_BITS - 1)) - (KW'(1) << (2 * COEF_BITS)));
            sel_reg     <= SEL_POOL;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg   <= cfg_data[10:0];
                REG_HEIGHT: height_reg  <= cfg_data[12:0];
                REG_K_TOP:  krow_reg[0] <= cfg_data[KW-1:0];
                REG_K_MID:  krow_reg[1] <= cfg_data[KW-1:0];
                REG_K_BOT:  krow_reg[2] <= cfg_data[KW-1:0];
                REG_SELECT: sel_reg     <= cfg_data[1:0];
                default:    ;
            endcase
        end
    end

    // clamped sizes
    logic [13:0] w_eff;
    logic [13:0] h_eff;
    always_comb
    begin
        w_eff = 14'(width_reg);
        if (width_reg < 11'd3)
        begin
            w_eff = 14'd3;
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_eff = 14'(MAX_WIDTH);
        end
        h_eff = 14'(height_reg);
        if (height_reg < 13'd3)
        begin
            h_eff = 14'd3;
        end
        else if (32'(height_reg) > MAX_H)
        begin
            h_eff = 14'(MAX_H);
        end
    end

    // global advance: the whole pipe moves unless a result waits under stall
    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;
    logic take;
    assign take = in_valid && adv;

    // pixel counters
    logic [13:0] col_reg;
    logic [13:0] row_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (take)
        begin
            if (col_reg + 14'd1 >= w_eff)
            begin
                col_reg <= '0;
                row_reg <= (row_reg + 14'd1 >= h_eff) ? 14'd0 : row_reg + 14'd1;
            end
            else
            begin
                col_reg <= col_reg + 14'd1;
            end
        end
    end

    // stage 1: gray, position, line read
    logic           s1_v_reg;
    logic [7:0]     s1_gray_reg;
    logic [AW-1:0]  s1_col_reg;
    logic [11:0]    s1_row_reg;
    logic           s1_last_reg;
    logic [2*GRAY_W-1:0] line_rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= in_valid;
        end
    end
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_gray_reg <= gray_of(red, green, blue);
            s1_col_reg  <= col_reg[AW-1:0];
            s1_row_reg  <= row_reg[11:0];
            s1_last_reg <= (row_reg == h_eff - 14'd1) && (col_reg == w_eff - 14'd1);
        end
    end

    gcap_line_mem #(.DEPTH(MAX_WIDTH), .AW(AW)) u_line (
        .clk     (clk),
        .rd_en   (take),
        .rd_addr (col_reg[AW-1:0]),
        .rd_data (line_rd),
        .wr_en   (s1_v_reg && adv),
        .wr_addr (s1_col_reg),
        .wr_data ({s1_gray_reg, line_rd[2*GRAY_W-1:GRAY_W]})
    );

    // window columns: [0] col-2, [1] col-1; each holds rows {0,1,2}
    logic [7:0] win_reg [2][3];
    logic [7:0] cur [3];
    assign cur[0] = line_rd[GRAY_W-1:0];
    assign cur[1] = line_rd[2*GRAY_W-1:GRAY_W];
    assign cur[2] = s1_gray_reg;

    function automatic logic signed [COEF_BITS-1:0] coef(input logic [KW-1:0] r, input int c);
        coef = r[c*COEF_BITS +: COEF_BITS];
    endfunction

    // 9 taps of signed coef x 8-bit pixel; fits 32 bits for COEF_BITS <= 16
    logic signed [31:0] conv_c;
    always_comb
    begin
        conv_c = '0;
        for (int kr = 0; kr < 3; kr++)
        begin
            conv_c = conv_c
                   + 32'(coef(krow_reg[kr], 0)) * $signed({1'b0, win_reg[0][kr]})
                   + 32'(coef(krow_reg[kr], 1)) * $signed({1'b0, win_reg[1][kr]})
                   + 32'(coef(krow_reg[kr], 2)) * $signed({1'b0, cur[kr]});
        end
    end

    // stage 2 registers
    logic               s2_v_reg;
    logic signed [31:0] s2_conv_reg;
    logic [11:0]        s2_cr_reg;
    logic [AW-1:0]      s2_cc_reg;
    logic               s2_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_v_reg <= s1_v_reg && s1_row_reg >= 12'd2 && 32'(s1_col_reg) >= 2;
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv && s1_v_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[0][k] <= win_reg[1][k];
                win_reg[1][k] <= cur[k];
            end
            s2_conv_reg <= conv_c;
            s2_cr_reg   <= s1_row_reg - 12'd2;
            s2_cc_reg   <= s1_col_reg - AW'(2);
            s2_last_reg <= s1_last_reg;
        end
    end

    // stage 3: ReLU, pair, pool read
    logic [31:0]   act2;
    assign act2 = (s2_conv_reg > 0) ? 32'(s2_conv_reg) : 32'd0;
    logic [PAW-1:0] pidx2;
    assign pidx2 = PAW'(s2_cc_reg >> 1);
    logic [18:0]   partial_reg;
    logic [19:0]   pair2;
    assign pair2 = 20'(partial_reg) + act2[19:0];

    logic               s3_v_reg;
    logic               s3_odd_reg;
    logic               s3_rodd_reg;
    logic [19:0]        s3_pair_reg;
    logic signed [19:0] s3_val_reg;
    logic [11:0]        s3_cr_reg;
    logic [AW-1:0]      s3_cc_reg;
    logic               s3_last_reg;
    logic [PAW-1:0]     s3_pidx_reg;
    logic [VALUE_W-1:0] pool_rd;
    logic               s3_wr;
    assign s3_wr = s3_v_reg && s3_odd_reg && !s3_rodd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg    <= 1'b0;
            partial_reg <= '0;
        end
        else if (adv)
        begin
            s3_v_reg <= s2_v_reg;
            if (s2_v_reg && !s2_cc_reg[0])
            begin
                partial_reg <= act2[18:0];
            end
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv && s2_v_reg)
        begin
            s3_odd_reg  <= s2_cc_reg[0];
            s3_rodd_reg <= s2_cr_reg[0];
            s3_pair_reg <= pair2;
            s3_val_reg  <= (sel_reg == SEL_CONV) ? s2_conv_reg[19:0] : act2[19:0];
            s3_cr_reg   <= s2_cr_reg;
            s3_cc_reg   <= s2_cc_reg;
            s3_last_reg <= s2_last_reg;
            s3_pidx_reg <= pidx2;
        end
    end

    gcap_pool_mem #(.DEPTH(PD), .AW(PAW)) u_pool (
        .clk     (clk),
        .rd_en   (adv && s2_v_reg),
        .rd_addr (pidx2),
        .rd_data (pool_rd),
        .wr_en   (adv && s3_wr),
        .wr_addr (s3_pidx_reg),
        .wr_data (s3_pair_reg)
    );

    // stage 4: result
    logic [13:0] pn;
    logic [13:0] pm;
    assign pn = (h_eff - 14'd2) >> 1;
    assign pm = (w_eff - 14'd2) >> 1;
    // keep the carry: the four-term sum can exceed 20 bits
    logic [20:0] psum;
    assign psum = 21'(pool_rd) + 21'(s3_pair_reg);

    logic emit;
    always_comb
    begin
        if (sel_reg == SEL_CONV || sel_reg == SEL_ACT)
        begin
            emit = s3_v_reg;
        end
        else
        begin
            emit = s3_v_reg && s3_odd_reg && s3_rodd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            out_valid <= emit;
        end
    end
    always_ff @(posedge clk)
    begin
        if (adv && emit)
        begin
            if (sel_reg == SEL_CONV || sel_reg == SEL_ACT)
            begin
                value      <= s3_val_reg;
                out_row    <= s3_cr_reg;
                out_col    <= COL_W'(s3_cc_reg);
                frame_last <= s3_last_reg;
            end
            else
            begin
                value      <= $signed(VALUE_W'(psum >> 2));
                out_row    <= 12'(s3_cr_reg >> 1);
                out_col    <= COL_W'(s3_cc_reg >> 1);
                frame_last <= pn > 0 && pm > 0 && 14'(s3_cr_reg >> 1) == pn - 14'd1 &&
                              14'(s3_cc_reg >> 1) == pm - 14'd1;
            end
        end
    end

    // held result may not change while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value))
        else $error("result changed under stall");
    a_install: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without cause");
    a_pool: assert property (@(posedge clk) disable iff (!rst_n)
        s3_wr |-> !(s3_odd_reg && s3_rodd_reg))
        else $error("pool write on odd row");
endmodule
`default_nettype wire

// ===== src/gcap_line_mem.sv =====
// Dual line buffer memory: one entry per column holds the two previous rows' gray.
// Uses gcap_pkg.
`default_nettype none
module gcap_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                          clk,
    input  wire logic                          rd_en,
    input  wire logic [AW-1:0]                 rd_addr,
    output logic      [2*gcap_pkg::GRAY_W-1:0] rd_data,
    input  wire logic                          wr_en,
    input  wire logic [AW-1:0]                 wr_addr,
    input  wire logic [2*gcap_pkg::GRAY_W-1:0] wr_data
);
    import gcap_pkg::*;
    logic [2*GRAY_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== src/gcap_pool_mem.sv =====
// Pool row-sum memory: one pair sum per pool column from the even conv row.
// Uses gcap_pkg.
`default_nettype none
module gcap_pool_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  wire logic                          clk,
    input  wire logic                          rd_en,
    input  wire logic [AW-1:0]                 rd_addr,
    output logic      [gcap_pkg::VALUE_W-1:0]  rd_data,
    input  wire logic                          wr_en,
    input  wire logic [AW-1:0]                 wr_addr,
    input  wire logic [gcap_pkg::VALUE_W-1:0]  wr_data
);
    import gcap_pkg::*;
    logic [VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire
